// File: rtl/core/tscv_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tscv_pkg
// Shared widths, defaults, register indexes and the command and status
// types passed between the touch qualifier controller and its datapath.
// ----------------------------------------------------------------------------
package tscv_pkg;

    localparam int SAMPLE_W      = 11;
    localparam int THR_W         = 12;
    localparam int TOFF_W        = 8;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 11;
    localparam int S_TDATA_W     = 16;
    localparam int M_TDATA_W     = 24;

    localparam int DEF_CAL_SAMPLES = 10;
    localparam int DEF_VOTE_TRIES  = 1;

    localparam logic [TOFF_W-1:0]   TOUCH_OFFSET_RST = 8'd9;
    localparam logic [SAMPLE_W-1:0] WRAP_OFFSET_RST  = 11'd1000;

    localparam logic [CFG_IDX_W-1:0] REG_TOUCH_OFFSET = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WRAP_OFFSET  = 1'd1;

    localparam logic KIND_CAL   = 1'b0;
    localparam logic KIND_SENSE = 1'b1;

    typedef struct packed {
        logic accept;
        logic decode;
        logic load_i;
        logic scan;
        logic eval;
        logic fin;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic is_cal;
        logic cal_last;
        logic win_last;
        logic scan_last;
        logic outer_last;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

// File: rtl/core/touch_sensor_mode_calibrate_vote.sv
`default_nettype none
// ----------------------------------------------------------------------------
// touch_sensor_mode_calibrate_vote
// Touch sensor qualifier. Items enter on the s_axis channel: tuser carries
// the item kind (0 calibration, 1 sense), tdata the 11-bit sample.
// Calibration samples are stored; once CAL_SAMPLES have arrived the most
// frequent value (first seen wins a tie) becomes the mode, and the threshold
// is the mode plus the touch offset. A calibration result is then sent.
// Sense samples above the wrap offset lose that offset and vote against the
// threshold; every 2*VOTE_TRIES+1 sense samples give a majority decision.
// Registers are written on the cfg channel, which is always ready.
// An item is taken only in the idle state; a decision passes through the decode
// and emit states to the output register. The completing calibration sample
// waits for the mode search, which compares every stored pair through one
// pair of store read ports.
// When the receiver stalls, the result waits in the output register and the
// block goes on taking items; it holds its input only once a second result
// is ready. Reset restores the register defaults and clears the sample, vote
// and outer-loop counts, the mode and the threshold; the store needs no clearing.
// ----------------------------------------------------------------------------
module touch_sensor_mode_calibrate_vote #(
    parameter int CAL_SAMPLES = tscv_pkg::DEF_CAL_SAMPLES,
    parameter int VOTE_TRIES  = tscv_pkg::DEF_VOTE_TRIES
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               s_axis_tvalid,
    output logic                              s_axis_tready,
    // tdata: sample [10:0], zero fill [15:11]
    input  wire  [tscv_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // tuser: req_type [0]
    input  wire  [0:0]                        s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  wire                               m_axis_tready,
    // tdata: touch [0], baseline_mode [11:1], threshold_value [23:12]
    output logic [tscv_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    // tuser: result_kind [0]
    output logic [0:0]                        m_axis_tuser,
    input  wire                               i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire  [tscv_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire  [tscv_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import tscv_pkg::*;

    t_cmd                w_cmd;
    t_stat               w_stat;
    logic                w_out_kind;
    logic                w_out_touch;
    logic [SAMPLE_W-1:0] w_out_mode;
    logic [THR_W-1:0]    w_out_thr;

    assign o_cfg_ready = 1'b1;

    tscv_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    tscv_dpath #(
        .CAL_SAMPLES (CAL_SAMPLES),
        .VOTE_TRIES  (VOTE_TRIES)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_kind      (s_axis_tuser[0]),
        .i_sample    (s_axis_tdata[SAMPLE_W-1:0]),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_kind      (w_out_kind),
        .o_touch     (w_out_touch),
        .o_mode      (w_out_mode),
        .o_thr       (w_out_thr)
    );

    assign m_axis_tdata = {w_out_thr, w_out_mode, w_out_touch};
    assign m_axis_tuser = w_out_kind;

endmodule

`default_nettype wire

// File: rtl/core/tscv_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tscv_ctrl
// Sequencer for the touch qualifier: takes one item, decodes it, walks the
// calibration store for the mode search and hands results to the output.
// ----------------------------------------------------------------------------
module tscv_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    output logic             o_in_ready,
    input  tscv_pkg::t_stat  i_stat,
    output tscv_pkg::t_cmd   o_cmd
);
    import tscv_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DECODE = 3'd1;
    localparam logic [2:0] ST_LOAD_I = 3'd2;
    localparam logic [2:0] ST_SCAN   = 3'd3;
    localparam logic [2:0] ST_EVAL   = 3'd4;
    localparam logic [2:0] ST_FIN    = 3'd5;
    localparam logic [2:0] ST_EMIT   = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        o_in_ready = (r_state == ST_IDLE);
        o_cmd        = '0;
        o_cmd.accept = (r_state == ST_IDLE) && i_in_valid;
        o_cmd.decode = (r_state == ST_DECODE);
        o_cmd.load_i = (r_state == ST_LOAD_I);
        o_cmd.scan   = (r_state == ST_SCAN);
        o_cmd.eval   = (r_state == ST_EVAL);
        o_cmd.fin    = (r_state == ST_FIN);
        o_cmd.emit   = (r_state == ST_EMIT);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (i_stat.is_cal) begin
                    n_state = i_stat.cal_last ? ST_LOAD_I : ST_IDLE;
                end else begin
                    n_state = i_stat.win_last ? ST_EMIT : ST_IDLE;
                end
            end
            ST_LOAD_I: begin
                n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (i_stat.scan_last) begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                n_state = i_stat.outer_last ? ST_FIN : ST_LOAD_I;
            end
            ST_FIN: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_stat.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/tscv_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tscv_dpath
// Datapath of the touch qualifier: configuration registers, calibration
// store, mode search counters, vote window and the output register.
// ----------------------------------------------------------------------------
module tscv_dpath #(
    parameter int CAL_SAMPLES = tscv_pkg::DEF_CAL_SAMPLES,
    parameter int VOTE_TRIES  = tscv_pkg::DEF_VOTE_TRIES
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  tscv_pkg::t_cmd                      i_cmd,
    output tscv_pkg::t_stat                     o_stat,
    input  wire                                 i_kind,
    input  wire  [tscv_pkg::SAMPLE_W-1:0]       i_sample,
    input  wire                                 i_cfg_we,
    input  wire  [tscv_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire  [tscv_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  wire                                 i_out_ready,
    output logic                                o_out_valid,
    output logic                                o_kind,
    output logic                                o_touch,
    output logic [tscv_pkg::SAMPLE_W-1:0]       o_mode,
    output logic [tscv_pkg::THR_W-1:0]          o_thr
);
    import tscv_pkg::*;

    localparam int IDX_W  = $clog2(CAL_SAMPLES);
    localparam int CNT_W  = $clog2(CAL_SAMPLES + 1);
    localparam int WIN    = 2 * VOTE_TRIES + 1;
    localparam int SEEN_W = $clog2(WIN + 1);
    localparam logic [IDX_W-1:0]  IDX_LAST  = IDX_W'(CAL_SAMPLES - 1);
    localparam logic [SEEN_W-1:0] SEEN_WIN  = SEEN_W'(WIN);
    localparam logic [SEEN_W-1:0] TALLY_MIN = SEEN_W'(VOTE_TRIES + 1);

    logic [SAMPLE_W-1:0] r_mem [CAL_SAMPLES];
    logic [SAMPLE_W-1:0] r_rd_a;
    logic [SAMPLE_W-1:0] r_rd_b;
    logic [IDX_W-1:0]    w_addr_b;

    logic [TOFF_W-1:0]   r_toff;
    logic [SAMPLE_W-1:0] r_wrap;
    logic                r_kind;
    logic [SAMPLE_W-1:0] r_sample;
    logic [IDX_W-1:0]    r_count;
    logic [IDX_W-1:0]    r_i;
    logic [IDX_W-1:0]    r_j;
    logic [CNT_W-1:0]    r_cnt;
    logic [CNT_W-1:0]    r_best_cnt;
    logic [SAMPLE_W-1:0] r_best;
    logic [SAMPLE_W-1:0] r_mode;
    logic [THR_W-1:0]    r_thr;
    logic [SEEN_W-1:0]   r_seen;
    logic [SEEN_W-1:0]   r_tally;
    logic                r_touch;
    logic                r_out_vld;
    logic                r_out_kind;
    logic                r_out_touch;
    logic [SAMPLE_W-1:0] r_out_mode;
    logic [THR_W-1:0]    r_out_thr;

    logic [SAMPLE_W-1:0] w_adj;
    logic                w_vote;
    logic [SEEN_W-1:0]   w_seen_n;
    logic [SEEN_W-1:0]   w_tally_n;
    logic                w_out_free;

    always_comb begin
        w_adj     = (r_sample > r_wrap) ? (r_sample - r_wrap) : r_sample;
        w_vote    = ({1'b0, w_adj} > r_thr);
        w_seen_n  = r_seen + SEEN_W'(1);
        w_tally_n = r_tally + SEEN_W'(w_vote);
        w_out_free = !r_out_vld || i_out_ready;
        if (i_cmd.scan && (r_j != IDX_LAST)) begin
            w_addr_b = r_j + IDX_W'(1);
        end else begin
            w_addr_b = '0;
        end
        o_stat.is_cal     = (r_kind == KIND_CAL);
        o_stat.cal_last   = (r_count == IDX_LAST);
        o_stat.win_last   = (w_seen_n == SEEN_WIN);
        o_stat.scan_last  = (r_j == IDX_LAST);
        o_stat.outer_last = (r_i == IDX_LAST);
        o_stat.out_free   = w_out_free;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.decode && (r_kind == KIND_CAL)) begin
            r_mem[r_count] <= r_sample;
        end
        r_rd_a <= r_mem[r_i];
        r_rd_b <= r_mem[w_addr_b];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_kind   <= i_kind;
            r_sample <= i_sample;
        end
        if (i_cmd.load_i) begin
            r_j   <= '0;
            r_cnt <= '0;
        end
        if (i_cmd.scan) begin
            r_j   <= r_j + IDX_W'(1);
            r_cnt <= r_cnt + CNT_W'(r_rd_a == r_rd_b);
        end
        if (i_cmd.eval && (r_cnt > r_best_cnt)) begin
            r_best     <= r_rd_a;
            r_best_cnt <= r_cnt;
        end
        if (i_cmd.decode && (r_kind == KIND_CAL) && (r_count == IDX_LAST)) begin
            r_best_cnt <= '0;
        end
        if (i_cmd.decode) begin
            if (r_kind == KIND_CAL) begin
                r_touch <= 1'b0;
            end else begin
                r_touch <= (w_tally_n >= TALLY_MIN);
            end
        end
        if (i_cmd.emit && w_out_free) begin
            r_out_kind  <= r_kind;
            r_out_touch <= r_touch;
            r_out_mode  <= r_mode;
            r_out_thr   <= r_thr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_toff    <= TOUCH_OFFSET_RST;
            r_wrap    <= WRAP_OFFSET_RST;
            r_count   <= '0;
            r_i       <= '0;
            r_seen    <= '0;
            r_tally   <= '0;
            r_mode    <= '0;
            r_thr     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_TOUCH_OFFSET: r_toff <= i_cfg_data[TOFF_W-1:0];
                    REG_WRAP_OFFSET:  r_wrap <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (i_cmd.decode) begin
                if (r_kind == KIND_CAL) begin
                    r_seen  <= '0;
                    r_tally <= '0;
                    if (r_count == IDX_LAST) begin
                        r_count <= '0;
                        r_i     <= '0;
                    end else begin
                        r_count <= r_count + IDX_W'(1);
                    end
                end else if (w_seen_n == SEEN_WIN) begin
                    r_seen  <= '0;
                    r_tally <= '0;
                end else begin
                    r_seen  <= w_seen_n;
                    r_tally <= w_tally_n;
                end
            end
            if (i_cmd.eval) begin
                r_i <= (r_i == IDX_LAST) ? '0 : r_i + IDX_W'(1);
            end
            if (i_cmd.fin) begin
                r_mode <= r_best;
                r_thr  <= {1'b0, r_best} + {{(THR_W - TOFF_W){1'b0}}, r_toff};
            end
            if (i_cmd.emit && w_out_free) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_kind      = r_out_kind;
    assign o_touch     = r_out_touch;
    assign o_mode      = r_out_mode;
    assign o_thr       = r_out_thr;

`ifndef ASSERT_OFF
    a_seen_below_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen < SEEN_WIN)
        else $error("vote window count reached the window length");
    a_tally_le_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tally <= r_seen)
        else $error("touch tally exceeds samples seen");
    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= IDX_LAST)
        else $error("calibration count out of range");
    a_fin_threshold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fin |=> (r_thr == ({1'b0, r_mode} + {{(THR_W - TOFF_W){1'b0}}, r_toff})))
        else $error("threshold does not follow the calibrated mode");
`endif

endmodule

`default_nettype wire

// File: tb/tscv_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tscv_checker
// Watches the sample, result and register channels of the touch qualifier.
// It keeps its own copy of the calibration store, threshold and vote window,
// works out the result that each sample transfer should give, and compares
// every result transfer field by field with the oldest outstanding one.
// ----------------------------------------------------------------------------
module tscv_checker #(
    parameter int CAL_SAMPLES = tscv_pkg::DEF_CAL_SAMPLES,
    parameter int VOTE_TRIES  = tscv_pkg::DEF_VOTE_TRIES
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_s_tvalid,
    input  wire                               i_s_tready,
    // tdata: sample [10:0], zero fill [15:11]
    input  wire  [tscv_pkg::S_TDATA_W-1:0]    i_s_tdata,
    // tuser: req_type [0]
    input  wire  [0:0]                        i_s_tuser,
    input  wire                               i_m_tvalid,
    input  wire                               i_m_tready,
    // tdata: touch [0], baseline_mode [11:1], threshold_value [23:12]
    input  wire  [tscv_pkg::M_TDATA_W-1:0]    i_m_tdata,
    // tuser: result_kind [0]
    input  wire  [0:0]                        i_m_tuser,
    input  wire                               i_cfg_valid,
    input  wire                               i_cfg_ready,
    input  wire  [tscv_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire  [tscv_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output int                                o_fail_count,
    output int                                o_pending,
    output int                                o_cal_reports,
    output int                                o_decisions,
    output int                                o_touches
);
    import tscv_pkg::*;

    typedef struct packed {
        logic                kind;
        logic                touch;
        logic [SAMPLE_W-1:0] mode;
        logic [THR_W-1:0]    threshold;
    } t_report;

    logic [TOFF_W-1:0]   touch_offset;
    logic [SAMPLE_W-1:0] wrap_offset;
    logic [SAMPLE_W-1:0] cal_store [CAL_SAMPLES];
    int                  cal_fill;
    logic [THR_W-1:0]    threshold;
    logic [SAMPLE_W-1:0] mode;
    logic [3:0]          votes_seen;
    logic [3:0]          votes_touch;
    t_report             reports_due [$];

    int fail_count  = 0;
    int pending     = 0;
    int cal_reports = 0;
    int decisions   = 0;
    int touches     = 0;

    assign o_fail_count  = fail_count;
    assign o_pending     = pending;
    assign o_cal_reports = cal_reports;
    assign o_decisions   = decisions;
    assign o_touches     = touches;

    // Most frequent stored value; a tie goes to the value that appears first.
    function automatic logic [SAMPLE_W-1:0] stored_mode();
        logic [SAMPLE_W-1:0] best;
        int                  best_hits;
        int                  hits;
        best      = cal_store[0];
        best_hits = 0;
        for (int i = 0; i < CAL_SAMPLES; i++) begin
            hits = 0;
            for (int j = 0; j < CAL_SAMPLES; j++) begin
                if (cal_store[j] == cal_store[i]) begin
                    hits++;
                end
            end
            if (hits > best_hits) begin
                best_hits = hits;
                best      = cal_store[i];
            end
        end
        return best;
    endfunction

    task automatic qualify_sample(input logic kind, input logic [SAMPLE_W-1:0] raw);
        t_report             rep;
        logic [SAMPLE_W-1:0] level;
        if (kind == KIND_CAL) begin
            votes_seen  = '0;
            votes_touch = '0;
            cal_store[cal_fill] = raw;
            cal_fill++;
            if (cal_fill == CAL_SAMPLES) begin
                cal_fill      = 0;
                mode          = stored_mode();
                threshold     = THR_W'(mode) + THR_W'(touch_offset);
                rep.kind      = KIND_CAL;
                rep.touch     = 1'b0;
                rep.mode      = mode;
                rep.threshold = threshold;
                reports_due.push_back(rep);
            end
        end else begin
            level = (raw > wrap_offset) ? raw - wrap_offset : raw;
            if (THR_W'(level) > threshold) begin
                votes_touch++;
            end
            votes_seen++;
            if (votes_seen == 2 * VOTE_TRIES + 1) begin
                rep.kind      = KIND_SENSE;
                rep.touch     = (votes_touch >= VOTE_TRIES + 1);
                rep.mode      = mode;
                rep.threshold = threshold;
                reports_due.push_back(rep);
                votes_seen  = '0;
                votes_touch = '0;
            end
        end
    endtask

    task automatic check_field(input string label, input int want, input int got);
        if (want != got) begin
            fail_count++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, label, want, got);
        end
    endtask

    task automatic compare_report();
        t_report want;
        if (reports_due.size() == 0) begin
            fail_count++;
            $display({"%0t: unexpected result: expected none, ",
                      "actual kind %0d touch %0d mode %0d threshold %0d"},
                     $time, i_m_tuser[0], i_m_tdata[0], i_m_tdata[11:1], i_m_tdata[23:12]);
        end else begin
            want = reports_due.pop_front();
            check_field("result kind", want.kind, i_m_tuser[0]);
            check_field("touch", want.touch, i_m_tdata[0]);
            check_field("baseline mode", want.mode, i_m_tdata[11:1]);
            check_field("threshold", want.threshold, i_m_tdata[23:12]);
            if (want.kind == KIND_CAL) begin
                cal_reports++;
            end else begin
                decisions++;
                if (want.touch) begin
                    touches++;
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            touch_offset = TOUCH_OFFSET_RST;
            wrap_offset  = WRAP_OFFSET_RST;
            cal_fill     = 0;
            threshold    = '0;
            mode         = '0;
            votes_seen   = '0;
            votes_touch  = '0;
            reports_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == REG_TOUCH_OFFSET) begin
                    touch_offset = i_cfg_data[TOFF_W-1:0];
                end else if (i_cfg_index == REG_WRAP_OFFSET) begin
                    wrap_offset = i_cfg_data[SAMPLE_W-1:0];
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                qualify_sample(i_s_tuser[0], i_s_tdata[SAMPLE_W-1:0]);
            end
            if (i_m_tvalid && i_m_tready) begin
                compare_report();
            end
        end
        pending <= reports_due.size();
    end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the touch qualifier with a short directed sequence followed by
// calibration runs, sense windows, broken sequences and noise under several
// register settings, with random gaps on the input and stalls on the output.
// The checker beside the block predicts and compares; this module gives the
// verdict.
// ----------------------------------------------------------------------------
module tb_top;
    import tscv_pkg::*;

    localparam int CAL_N        = DEF_CAL_SAMPLES;
    localparam int WINDOW       = 2 * DEF_VOTE_TRIES + 1;
    localparam int RANDOM_ITEMS = 1300;
    localparam int PHASES       = 8;
    localparam int SAMPLE_MAX   = (1 << SAMPLE_W) - 1;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    wire                   s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic [0:0]            s_axis_tuser  = '0;
    wire                   m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    wire  [M_TDATA_W-1:0]  m_axis_tdata;
    wire  [0:0]            m_axis_tuser;
    logic                  i_cfg_valid   = 1'b0;
    wire                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;

    int fail_count;
    int pending;
    int cal_reports;
    int decisions;
    int touches;

    int items_sent    = 0;
    int cal_fill      = 0;
    int vote_fill     = 0;
    int burst_left    = 0;
    int settings_used = 1;
    int cur_toff      = TOUCH_OFFSET_RST;
    int cur_wrap      = WRAP_OFFSET_RST;
    int thr_guess     = 0;
    int rx_cycle      = 0;

    always #4 i_clk = ~i_clk;

    touch_sensor_mode_calibrate_vote dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    tscv_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (s_axis_tvalid),
        .i_s_tready    (s_axis_tready),
        .i_s_tdata     (s_axis_tdata),
        .i_s_tuser     (s_axis_tuser),
        .i_m_tvalid    (m_axis_tvalid),
        .i_m_tready    (m_axis_tready),
        .i_m_tdata     (m_axis_tdata),
        .i_m_tuser     (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_cal_reports (cal_reports),
        .o_decisions   (decisions),
        .o_touches     (touches)
    );

    // The receiver cycles through always ready, random, mostly stalled and a
    // fixed duty pattern.
    always @(posedge i_clk) begin
        rx_cycle <= rx_cycle + 1;
        case ((rx_cycle / 256) % 4)
            0: begin
                m_axis_tready <= 1'b1;
            end
            1: begin
                m_axis_tready <= ($urandom_range(0, 1) == 1);
            end
            2: begin
                m_axis_tready <= ($urandom_range(0, 3) == 0);
            end
            default: begin
                m_axis_tready <= ((rx_cycle % 16) >= 6);
            end
        endcase
    end

    function automatic int clip(input int v);
        if (v < 0) begin
            return 0;
        end
        return (v > SAMPLE_MAX) ? SAMPLE_MAX : v;
    endfunction

    task automatic pace();
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, ($urandom_range(0, 7) == 0) ? 30 : 5)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 9) == 0) ? 80 : $urandom_range(0, 12);
        end
    endtask

    task automatic send_item(input logic kind, input int value);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= S_TDATA_W'(value);
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
        if (kind == KIND_CAL) begin
            vote_fill = 0;
            cal_fill  = (cal_fill + 1) % CAL_N;
        end else begin
            vote_fill = (vote_fill + 1) % WINDOW;
        end
        pace();
    endtask

    // Holds the input until every outstanding result has been taken.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_settings(input int toff, input int wrap);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= REG_TOUCH_OFFSET;
        i_cfg_data  <= CFG_DATA_W'(toff);
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_index <= REG_WRAP_OFFSET;
        i_cfg_data  <= CFG_DATA_W'(wrap);
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cur_toff = toff;
        cur_wrap = wrap;
        settings_used++;
    endtask

    function automatic int cal_value(input int base, input int style, input int k);
        case (style)
            0: return base;
            1: return clip(base + $urandom_range(0, 3));
            2: return $urandom_range(0, SAMPLE_MAX);
            default: return (k % 2 == 0) ? base : clip(base + 1);
        endcase
    endfunction

    // Sense values land around the expected threshold, half of them carrying
    // the wrap offset on top.
    function automatic int sense_value();
        int v;
        v = clip(thr_guess + $urandom_range(0, 8) - 4);
        if ($urandom_range(0, 1) == 1 && v + cur_wrap <= SAMPLE_MAX) begin
            v = v + cur_wrap;
        end
        return v;
    endfunction

    task automatic calibration_run(input int len);
        int pick;
        int base;
        int style;
        pick  = $urandom_range(0, 9);
        base  = (pick == 0) ? 0 : (pick == 1) ? SAMPLE_MAX : $urandom_range(0, SAMPLE_MAX);
        style = $urandom_range(0, 3);
        for (int k = 0; k < len; k++) begin
            send_item(KIND_CAL, cal_value(base, style, k));
        end
        if (style != 2) begin
            thr_guess = base + cur_toff;
        end
    endtask

    task automatic run_phase(input int quota);
        int start;
        int r;
        int len;
        start = items_sent;
        while (items_sent - start < quota) begin
            r = $urandom_range(0, 9);
            if (r <= 2) begin
                calibration_run(CAL_N - cal_fill);
            end else if (r <= 6) begin
                len = $urandom_range(1, 4) * WINDOW - vote_fill;
                for (int k = 0; k < len; k++) begin
                    send_item(KIND_SENSE, sense_value());
                end
            end else if (r == 7) begin
                len = $urandom_range(1, 6);
                for (int k = 0; k < len; k++) begin
                    send_item($urandom_range(0, 1), $urandom_range(0, SAMPLE_MAX));
                end
            end else if ($urandom_range(0, 1) == 1) begin
                // A vote window cut short by a calibration sample.
                len = $urandom_range(1, WINDOW - 1);
                for (int k = 0; k < len; k++) begin
                    send_item(KIND_SENSE, sense_value());
                end
                send_item(KIND_CAL, clip(thr_guess - cur_toff));
            end else begin
                // A calibration run with sense samples in the middle of it.
                calibration_run($urandom_range(1, CAL_N - 1));
                len = $urandom_range(1, WINDOW);
                for (int k = 0; k < len; k++) begin
                    send_item(KIND_SENSE, sense_value());
                end
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Sense before any calibration, against a threshold of zero.
        send_item(KIND_SENSE, 0);
        send_item(KIND_SENSE, 1000);
        send_item(KIND_SENSE, SAMPLE_MAX);
        // Tie between two values; the one seen first must win.
        send_item(KIND_CAL, 0);
        send_item(KIND_CAL, 7);
        send_item(KIND_CAL, 7);
        send_item(KIND_CAL, 5);
        send_item(KIND_CAL, 5);
        send_item(KIND_CAL, SAMPLE_MAX);
        send_item(KIND_CAL, 1);
        send_item(KIND_CAL, 2);
        send_item(KIND_CAL, 3);
        send_item(KIND_CAL, 4);
        thr_guess = 16;
        // A calibration sample drops the partial window; the sense samples
        // that follow sit inside the new calibration run.
        send_item(KIND_SENSE, 17);
        send_item(KIND_CAL, SAMPLE_MAX);
        send_item(KIND_SENSE, SAMPLE_MAX);
        send_item(KIND_SENSE, 16);
        send_item(KIND_SENSE, 1017);

        for (int p = 0; p < PHASES; p++) begin
            settle();
            case (p)
                0: write_settings(0, 0);
                1: write_settings(255, SAMPLE_MAX);
                2: write_settings(255, 0);
                3: write_settings(0, SAMPLE_MAX);
                4: write_settings(TOUCH_OFFSET_RST, WRAP_OFFSET_RST);
                default: write_settings($urandom_range(0, 255), $urandom_range(0, SAMPLE_MAX));
            endcase
            run_phase(RANDOM_ITEMS / PHASES);
        end

        settle();
        repeat (20) @(posedge i_clk);
        $display("Run covered %0d sample transfers under %0d register settings.",
                 items_sent, settings_used);
        $display("Checked %0d calibration reports and %0d touch decisions (%0d touched).",
                 cal_reports, decisions, touches);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Run timed out with %0d results outstanding.", pending);
        $display("Test completed with failures");
        $finish;
    end

endmodule
